// ----- rtl/rcfr_pkg.sv -----
// Package for the RC serial frame receiver.
// Holds the frame constants, register codes and the structs passed between stages.
// Depends on nothing.
`timescale 1ns / 1ps

package rcfr_pkg;

  localparam int FRAME_BYTES  = 32;
  localparam int POS_W        = $clog2(FRAME_BYTES);
  localparam int SUM_BYTES    = 30;
  localparam int OUT_CHANNELS = 6;
  localparam int CH_IDX_W     = 4;

  localparam logic [7:0]  START_BYTE  = 8'h20;
  localparam logic [7:0]  HEADER_BYTE = 8'h40;
  localparam logic [15:0] SUM_INIT    = 16'hFFFF;
  localparam logic [15:0] SILENCE_MAX = 16'hFFFF;
  localparam logic        MODE_TICK   = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET    = 16'd500;
  localparam logic [15:0] VALID_LOW_RESET  = 16'd1000;
  localparam logic [15:0] VALID_HIGH_RESET = 16'd2000;

  typedef enum logic [1:0] {
    CFG_TIMEOUT    = 2'd0,
    CFG_VALID_LOW  = 2'd1,
    CFG_VALID_HIGH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] valid_low;
    logic [15:0] valid_high;
  } cfg_t;

  // What the collect stage hands to the update stage for one word.
  typedef struct packed {
    logic                tick_timeout;
    logic                finish;
    logic                hdr_ok;
    logic                pair_wr;
    logic [CH_IDX_W-1:0] pair_idx;
    logic [7:0]          data;
    logic [15:0]         sum;
  } stage_t;

endpackage

// ----- rtl/rc_serial_frame_receiver.sv -----
// A word accepted at an edge is registered in the collect stage, then its result word is
// written into the output register by the update stage once that register is free.
// Throughput: one word per cycle unless the output stalls; the collect stage reads the
// frame store once per word and the update stage retires one word per cycle into the output register when it is free.
// Reset: asynchronous, active low; clears parser, channels, failsafe (set) and the
// configuration registers to their defaults. The frame store is not cleared.
`timescale 1ns / 1ps

module rc_serial_frame_receiver import rcfr_pkg::*; #(
  parameter int USER_CHANNELS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] channel_one_o,
  output logic [15:0] channel_two_o,
  output logic [15:0] channel_three_o,
  output logic [15:0] channel_four_o,
  output logic [15:0] channel_five_o,
  output logic [15:0] channel_six_o,
  output logic        failsafe_o,
  output logic        frame_accepted_o
);

  cfg_t        cfg_q;
  logic        accept;
  stage_t      stage;
  logic [7:0]  rd_data;
  logic [15:0] out_ch [OUT_CHANNELS];

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TIMEOUT_RESET;
      cfg_q.valid_low     <= VALID_LOW_RESET;
      cfg_q.valid_high    <= VALID_HIGH_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_data_i;
        CFG_VALID_LOW:  cfg_q.valid_low     <= cfg_data_i;
        CFG_VALID_HIGH: cfg_q.valid_high    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rcfr_collect #(
    .USER_CHANNELS(USER_CHANNELS)
  ) u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .cfg_i       (cfg_q),
    .stage_o     (stage),
    .rd_data_o   (rd_data)
  );

  rcfr_update #(
    .USER_CHANNELS(USER_CHANNELS)
  ) u_update (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_accept_i      (accept),
    .in_ready_o       (in_ready_o),
    .stage_i          (stage),
    .rd_data_i        (rd_data),
    .cfg_i            (cfg_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_ch_o         (out_ch),
    .failsafe_o       (failsafe_o),
    .frame_accepted_o (frame_accepted_o)
  );

  assign channel_one_o   = out_ch[0];
  assign channel_two_o   = out_ch[1];
  assign channel_three_o = out_ch[2];
  assign channel_four_o  = out_ch[3];
  assign channel_five_o  = out_ch[4];
  assign channel_six_o   = out_ch[5];

endmodule

// ----- rtl/rcfr_collect.sv -----
// Collect stage: start-byte hunt, byte position, checksum and silence counter.
// Owns the frame store memory and reads back the earlier byte of each pair.
// Depends on rcfr_pkg.
`timescale 1ns / 1ps

module rcfr_collect import rcfr_pkg::*; #(
  parameter int USER_CHANNELS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  cfg_t        cfg_i,
  output stage_t      stage_o,
  output logic [7:0]  rd_data_o
);

  localparam int PAIR_LAST = 2 * USER_CHANNELS + 1;

  logic             collecting_q, collecting_d;
  logic [POS_W-1:0] count_q, count_d;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      silence_q, silence_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic             mem_we;
  logic             is_byte;
  stage_t           st;
  stage_t           stage_q;
  logic [7:0]       rd_q;
  logic [7:0]       mem_q [FRAME_BYTES];

  assign is_byte = (mode_i != MODE_TICK);

  always_comb begin
    collecting_d = collecting_q;
    count_d      = count_q;
    sum_d        = sum_q;
    hdr_ok_d     = hdr_ok_q;
    mem_we       = 1'b0;
    st           = '0;
    st.data      = data_byte_i;

    if (is_byte) begin
      silence_d = '0;
    end else if (silence_q != SILENCE_MAX) begin
      silence_d = silence_q + 16'd1;
    end else begin
      silence_d = silence_q;
    end

    if (is_byte) begin
      if (!collecting_q) begin
        if (data_byte_i == START_BYTE) begin
          collecting_d = 1'b1;
          count_d      = POS_W'(1);
          sum_d        = SUM_INIT - {8'h00, data_byte_i};
          mem_we       = 1'b1;
        end
      end else begin
        mem_we = 1'b1;
        if (count_q < POS_W'(SUM_BYTES)) begin
          sum_d = sum_q - {8'h00, data_byte_i};
        end
        if (count_q == POS_W'(1)) begin
          hdr_ok_d = (data_byte_i == HEADER_BYTE);
        end
        // The high byte of a channel pair; its low byte is read back from the store.
        if (count_q[0] && (count_q >= POS_W'(3)) && (count_q <= POS_W'(PAIR_LAST))) begin
          st.pair_wr  = 1'b1;
          st.pair_idx = CH_IDX_W'((count_q - POS_W'(3)) >> 1);
        end
        if (count_q == POS_W'(FRAME_BYTES - 1)) begin
          st.finish    = 1'b1;
          collecting_d = 1'b0;
          count_d      = '0;
        end else begin
          count_d = count_q + POS_W'(1);
        end
      end
    end

    st.sum          = sum_d;
    st.hdr_ok       = hdr_ok_q;
    st.tick_timeout = !is_byte && (silence_d > cfg_i.timeout_ticks);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      count_q      <= '0;
      sum_q        <= SUM_INIT;
      silence_q    <= '0;
      hdr_ok_q     <= 1'b0;
    end else if (accept_i) begin
      collecting_q <= collecting_d;
      count_q      <= count_d;
      sum_q        <= sum_d;
      silence_q    <= silence_d;
      hdr_ok_q     <= hdr_ok_d;
    end
  end

  // Frame store. The byte one position back was written at an earlier edge,
  // so the read sees it without forwarding.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (mem_we) begin
        mem_q[count_q] <= data_byte_i;
      end
      rd_q    <= mem_q[count_q - POS_W'(1)];
      stage_q <= st;
    end
  end

  assign stage_o   = stage_q;
  assign rd_data_o = rd_q;

`ifndef ASSERT_OFF
  a_finish_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && st.finish) |=> (!collecting_q && (count_q == '0)))
    else $error("frame end did not return to start-byte hunt");
  a_tick_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !is_byte) |=> (silence_q != '0))
    else $error("silence counter wrapped on a tick");
`endif

endmodule

// ----- rtl/rcfr_update.sv -----
// Update stage: channel values, failsafe and the output register.
// Loads channels from the pair staging registers on a good frame end.
// Depends on rcfr_pkg.
`timescale 1ns / 1ps

module rcfr_update import rcfr_pkg::*; #(
  parameter int USER_CHANNELS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_accept_i,
  output logic        in_ready_o,
  input  stage_t      stage_i,
  input  logic [7:0]  rd_data_i,
  input  cfg_t        cfg_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_ch_o [OUT_CHANNELS],
  output logic        failsafe_o,
  output logic        frame_accepted_o
);

  logic        b_valid_q;
  logic        ov_q;
  logic        b_fire;
  logic [15:0] pair;
  logic [15:0] ch_q [USER_CHANNELS];
  logic [15:0] ch_d [USER_CHANNELS];
  logic [15:0] stage_q [USER_CHANNELS];
  logic [15:0] ch_view [OUT_CHANNELS];
  logic        fs_q, fs_d;
  logic        acc_d;
  logic [15:0] out_ch_q [OUT_CHANNELS];
  logic        out_fs_q, out_acc_q;

  assign b_fire     = b_valid_q && (!ov_q || out_ready_i);
  assign in_ready_o = !b_valid_q || b_fire;
  assign pair       = {stage_i.data, rd_data_i};

  always_comb begin
    ch_d  = ch_q;
    fs_d  = fs_q;
    acc_d = 1'b0;
    if (stage_i.tick_timeout) begin
      fs_d = 1'b1;
      for (int k = 0; k < USER_CHANNELS; k++) begin
        ch_d[k] = '0;
      end
    end
    if (stage_i.finish) begin
      fs_d = 1'b0;
      if (stage_i.hdr_ok && (pair == stage_i.sum)) begin
        acc_d = 1'b1;
        ch_d  = stage_q;
      end
    end
    for (int k = 0; k < USER_CHANNELS; k++) begin
      if ((ch_d[k] < cfg_i.valid_low) || (ch_d[k] > cfg_i.valid_high)) begin
        fs_d = 1'b1;
      end
    end
  end

  for (genvar gj = 0; gj < OUT_CHANNELS; gj++) begin : g_view
    if (gj < USER_CHANNELS) begin : g_used
      assign ch_view[gj] = ch_d[gj];
    end else begin : g_unused
      assign ch_view[gj] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      ov_q      <= 1'b0;
      fs_q      <= 1'b1;
      for (int k = 0; k < USER_CHANNELS; k++) begin
        ch_q[k] <= '0;
      end
    end else begin
      if (in_accept_i) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (b_fire) begin
        fs_q <= fs_d;
        ch_q <= ch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_ch_q  <= ch_view;
      out_fs_q  <= fs_d;
      out_acc_q <= acc_d;
      for (int k = 0; k < USER_CHANNELS; k++) begin
        if (stage_i.pair_wr && (stage_i.pair_idx == CH_IDX_W'(k))) begin
          stage_q[k] <= pair;
        end
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign out_ch_o         = out_ch_q;
  assign failsafe_o       = out_fs_q;
  assign frame_accepted_o = out_acc_q;

`ifndef ASSERT_OFF
  a_timeout_sets_fs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && stage_i.tick_timeout) |=> (fs_q && (ch_q[0] == '0)))
    else $error("timeout did not set failsafe and clear channels");
  a_channels_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && !stage_i.finish && !stage_i.tick_timeout) |=> $stable(ch_q[0]))
    else $error("channel changed without a frame end or timeout");
`endif

endmodule

// ----- bench/rc_serial_frame_receiver_tb.sv -----
// Self-checking bench for rc_serial_frame_receiver: frames, noise and tick runs
// go in, and every result word is checked against a local parser model.
// Depends on rcfr_pkg and the rc_serial_frame_receiver RTL.
`timescale 1ns / 1ps

import rcfr_pkg::*;

typedef struct packed {
  logic [OUT_CHANNELS-1:0][15:0] chan;
  logic                          failsafe;
  logic                          accepted;
} rc_word_t;

class rc_link_scoreboard;
  logic [15:0] timeout_ticks;
  logic [15:0] valid_low;
  logic [15:0] valid_high;
  bit          collecting;
  int          byte_count;
  logic [7:0]  frame_store [FRAME_BYTES];
  logic [15:0] running_sum;
  logic [15:0] silence_count;
  logic [15:0] chan [OUT_CHANNELS];
  bit          failsafe;
  rc_word_t    due_outputs [$];
  int          errors;
  int          words_checked;

  function new();
    timeout_ticks = TIMEOUT_RESET;
    valid_low     = VALID_LOW_RESET;
    valid_high    = VALID_HIGH_RESET;
    collecting    = 1'b0;
    byte_count    = 0;
    running_sum   = SUM_INIT;
    silence_count = '0;
    foreach (chan[k]) chan[k] = '0;
    failsafe      = 1'b1;
    errors        = 0;
    words_checked = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_TIMEOUT:    timeout_ticks = val;
      CFG_VALID_LOW:  valid_low = val;
      CFG_VALID_HIGH: valid_high = val;
      default: ;
    endcase
  endfunction

  // Advances the parser by one accepted word and queues the result it must give.
  function void track_word(logic mode, logic [7:0] data);
    rc_word_t w;
    w.accepted = 1'b0;
    if (mode == MODE_TICK) begin
      if (silence_count != SILENCE_MAX) silence_count++;
      if (silence_count > timeout_ticks) begin
        failsafe = 1'b1;
        foreach (chan[k]) chan[k] = '0;
      end
    end else begin
      silence_count = '0;
      if (!collecting) begin
        if (data == START_BYTE) begin
          frame_store[0] = data;
          byte_count     = 1;
          running_sum    = SUM_INIT - 16'(data);
          collecting     = 1'b1;
        end
      end else begin
        frame_store[byte_count] = data;
        if (byte_count < SUM_BYTES) running_sum = running_sum - 16'(data);
        byte_count++;
        if (byte_count == FRAME_BYTES) begin
          // Any complete frame clears failsafe; only a good one loads channels.
          collecting = 1'b0;
          byte_count = 0;
          failsafe   = 1'b0;
          if (frame_store[1] == HEADER_BYTE &&
              {frame_store[SUM_BYTES+1], frame_store[SUM_BYTES]} == running_sum) begin
            w.accepted = 1'b1;
            foreach (chan[k]) chan[k] = {frame_store[3+2*k], frame_store[2+2*k]};
          end
        end
      end
    end
    foreach (chan[k]) begin
      if (chan[k] < valid_low || chan[k] > valid_high) failsafe = 1'b1;
    end
    foreach (chan[k]) w.chan[k] = chan[k];
    w.failsafe = failsafe;
    due_outputs.push_back(w);
  endfunction

  task report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task compare_word(rc_word_t got);
    rc_word_t want;
    if (due_outputs.size() == 0) begin
      report("result word with nothing outstanding");
      return;
    end
    want = due_outputs.pop_front();
    for (int k = 0; k < OUT_CHANNELS; k++) begin
      if (got.chan[k] !== want.chan[k])
        report($sformatf("word %0d channel %0d: got %0d, want %0d",
                         words_checked, k + 1, got.chan[k], want.chan[k]));
    end
    if (got.failsafe !== want.failsafe)
      report($sformatf("word %0d failsafe: got %b, want %b",
                       words_checked, got.failsafe, want.failsafe));
    if (got.accepted !== want.accepted)
      report($sformatf("word %0d frame_accepted: got %b, want %b",
                       words_checked, got.accepted, want.accepted));
    words_checked++;
  endtask
endclass

module rc_serial_frame_receiver_tb;

  localparam logic       MODE_BYTE    = 1'b0;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int         PHASES       = 8;
  localparam int         RANDOM_ITEMS = 1100;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        mode_i      = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] channel_one_o, channel_two_o, channel_three_o;
  logic [15:0] channel_four_o, channel_five_o, channel_six_o;
  logic        failsafe_o;
  logic        frame_accepted_o;

  rc_link_scoreboard sb;
  rc_word_t          observed;
  bit                calm = 1'b0;
  int                items_sent = 0;

  logic [15:0] phase_timeout [PHASES] =
    '{16'd500, 16'd0, 16'd1, 16'hFFFF, 16'd5, 16'd3, 16'd0, 16'd20};
  logic [15:0] phase_low [PHASES] =
    '{16'd1000, 16'd0, 16'd1000, 16'd0, 16'hFFFF, 16'd2000, 16'd0, 16'd1000};
  logic [15:0] phase_high [PHASES] =
    '{16'd2000, 16'hFFFF, 16'd2000, 16'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd2000};

  rc_serial_frame_receiver u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_one_o   (channel_one_o),
    .channel_two_o   (channel_two_o),
    .channel_three_o (channel_three_o),
    .channel_four_o  (channel_four_o),
    .channel_five_o  (channel_five_o),
    .channel_six_o   (channel_six_o),
    .failsafe_o      (failsafe_o),
    .frame_accepted_o(frame_accepted_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("rc_serial_frame_receiver_tb: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 9);
  end

  assign observed = {channel_six_o, channel_five_o, channel_four_o, channel_three_o,
                     channel_two_o, channel_one_o, failsafe_o, frame_accepted_o};

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.compare_word(observed);
  end

  task automatic push_word(logic mode, logic [7:0] data);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    data_byte_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    sb.track_word(mode, data);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) push_word(MODE_TICK, 8'($urandom));
  endtask

  task automatic drain_outputs();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.due_outputs.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  // The unmapped index goes last so that an aliased write would stick.
  task automatic program_regs(logic [15:0] t, logic [15:0] lo, logic [15:0] hi);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    idx = '{CFG_TIMEOUT, CFG_VALID_LOW, CFG_VALID_HIGH, CFG_UNMAPPED};
    val = '{t, lo, hi, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Channel values cluster on and around the edges of the valid window.
  function automatic logic [15:0] pick_channel();
    logic [15:0] lo;
    logic [15:0] hi;
    int          r;
    lo = sb.valid_low;
    hi = sb.valid_high;
    r  = $urandom_range(0, 99);
    if (r < 10) return lo - 16'd1;
    if (r < 20) return hi + 16'd1;
    if (r < 28) return 16'($urandom);
    if (r < 40) return lo;
    if (r < 52) return hi;
    if (lo <= hi) return 16'($urandom_range(hi, lo));
    return 16'($urandom);
  endfunction

  task automatic send_frame();
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] v;
    logic [15:0] sum;
    // Finish whatever frame the parser is in the middle of first.
    while (sb.collecting) push_word(MODE_BYTE, 8'($urandom));
    fb[0] = START_BYTE;
    fb[1] = ($urandom_range(0, 99) < 90) ? HEADER_BYTE : 8'($urandom);
    for (int k = 0; k < OUT_CHANNELS; k++) begin
      v          = pick_channel();
      fb[2+2*k]  = v[7:0];
      fb[3+2*k]  = v[15:8];
    end
    for (int i = 2 + 2 * OUT_CHANNELS; i < SUM_BYTES; i++) fb[i] = 8'($urandom);
    sum = SUM_INIT;
    for (int i = 0; i < SUM_BYTES; i++) sum = sum - 16'(fb[i]);
    fb[SUM_BYTES]   = sum[7:0];
    fb[SUM_BYTES+1] = sum[15:8];
    if ($urandom_range(0, 99) < 8)
      fb[SUM_BYTES + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i > 0 && $urandom_range(0, 99) < 4) push_word(MODE_TICK, 8'($urandom));
      push_word(MODE_BYTE, fb[i]);
    end
  endtask

  task automatic random_phase(int stop_at);
    int r;
    int n;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_frame();
      end else if (r < 75) begin
        if ($urandom_range(0, 1) == 0 && sb.timeout_ticks < 64)
          n = int'(sb.timeout_ticks) + 1 + $urandom_range(0, 2);
        else
          n = $urandom_range(1, 8);
        send_ticks(n);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 5)) push_word(MODE_BYTE, 8'($urandom));
      end else begin
        // A stray start byte knocks the parser out of step with the frames.
        push_word(MODE_BYTE, START_BYTE);
      end
    end
  endtask

  initial begin
    logic [15:0] lo;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_word(MODE_TICK, 8'hFF);
    push_word(MODE_BYTE, 8'h00);
    push_word(MODE_BYTE, 8'hFF);
    push_word(MODE_BYTE, HEADER_BYTE);
    push_word(MODE_TICK, 8'h00);
    push_word(MODE_BYTE, 8'hAA);
    push_word(MODE_BYTE, 8'h55);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_outputs();
        if (phase_timeout[p] == 16'd0 && p != 1) begin
          lo = 16'($urandom);
          program_regs(16'($urandom_range(1, 40)), lo, 16'($urandom_range(65535, lo)));
        end else begin
          program_regs(phase_timeout[p], phase_low[p], phase_high[p]);
        end
      end
      calm = (p == PHASES - 1);
      random_phase(items_sent + RANDOM_ITEMS / PHASES);
      // Under the reset timeout, one run of silence long enough to trip it.
      if (p == 0) send_ticks(int'(sb.timeout_ticks) + 2);
    end

    drain_outputs();
    if (sb.due_outputs.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.due_outputs.size()));
    if (sb.errors == 0) begin
      $display("rc_serial_frame_receiver_tb: done, clean");
    end else begin
      $display("rc_serial_frame_receiver_tb: done, errors");
    end
    $finish;
  end

endmodule
